// ===== sv/hadf_pkg.sv =====
// ----------------------------------------------------------------------------
// HDLC deframer package
// Shared constants, types and the byte-wise FCS-16 update for the
// asynchronous HDLC deframer.
// ----------------------------------------------------------------------------
package hadf_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [15:0] FCS_INIT  = 16'hFFFF;
   localparam logic [15:0] FCS_POLY  = 16'h8408;

   localparam int MAX_FRAME_DEFAULT = 128;

   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_GOOD     = 3'd1;
   localparam logic [2:0] KIND_BADFCS   = 3'd2;
   localparam logic [2:0] KIND_SHORT    = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_ESCAPED = 2'd2
   } front_mode_type;

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_CLOSE = 2'd1,
      OP_ABORT = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
   } op_type;

   function automatic logic [15:0] fcs_update(input logic [15:0] crc,
                                              input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ FCS_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/hdlc_async_deframer_fcs16.sv =====
// ----------------------------------------------------------------------------
// Asynchronous HDLC deframer with FCS-16 check
// Top level: front end, operation queue and back end.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while req_full is low and can
// deliver one result per cycle while results are popped. A byte that yields a
// result is written into an operation queue entry and is then loaded into the
// back end's result register, where the byte-wide FCS-16 update sets the rate.
// Payload bytes appear two bytes late, as the last two bytes of a frame are its
// FCS, and each closed or aborted frame ends with one status result.
module hdlc_async_deframer_fcs16
   import hadf_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_frame_length
);

   logic   front_valid;
   op_type front_op;
   logic   q_full;
   logic   q_valid;
   logic   q_take;
   op_type q_op;
   logic   out_valid;

   hadf_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (req_push),
      .in_byte  (req_rx_byte),
      .op_full  (q_full),
      .op_valid (front_valid),
      .op       (front_op)
   );

   hadf_opq u_opq (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_op    (front_op),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_op    (q_op)
   );

   hadf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (q_valid),
      .op        (q_op),
      .op_take   (q_take),
      .out_valid (out_valid),
      .out_pop   (rsp_pop),
      .out_kind  (rsp_result_kind),
      .out_byte  (rsp_payload_byte),
      .out_len   (rsp_frame_length)
   );

   assign req_full  = q_full;
   assign rsp_empty = !out_valid;

`ifndef SYNTHESIS
   a_status_has_no_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_DATA) |-> (rsp_payload_byte == 8'h00))
      else $error("Status result carries a payload byte.");

   a_data_has_no_length: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == KIND_DATA) |-> (rsp_frame_length == 8'h00))
      else $error("Payload result carries a frame length.");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (32'(rsp_frame_length) <= 32'(MAX_FRAME)))
      else $error("Frame length beyond the maximum frame size.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_kind)))
      else $error("Waiting result changed before transfer.");
`endif

endmodule

// ===== sv/hadf_front.sv =====
// ----------------------------------------------------------------------------
// HDLC deframer front end
// Tracks flags and escapes, counts data bytes and turns received bytes into
// data, close or abort operations for the back end.
// ----------------------------------------------------------------------------
module hadf_front
   import hadf_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_push,
   input  logic [7:0] in_byte,
   input  logic       op_full,
   output logic       op_valid,
   output op_type     op
);

   localparam int CW = $clog2(MAX_FRAME + 3);
   localparam logic [CW-1:0] LIMIT = CW'(MAX_FRAME + 2);

   front_mode_type mode_ff, mode_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           accept;
   logic [7:0]     dbyte;
   logic           at_limit;

   assign accept   = in_push && !op_full;
   assign dbyte    = (mode_ff == MODE_ESCAPED) ? (in_byte ^ ESC_XOR) : in_byte;
   assign at_limit = (cnt_ff == LIMIT);

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         unique case (mode_ff)
            MODE_COLLECT: begin
               if (in_byte == ESC_BYTE) begin
                  mode_in = MODE_ESCAPED;
               end else if (in_byte == FLAG_BYTE) begin
                  if (cnt_ff != '0) begin
                     mode_in = MODE_IDLE;
                     cnt_in  = '0;
                  end
               end else if (at_limit) begin
                  mode_in = MODE_IDLE;
                  cnt_in  = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            MODE_ESCAPED: begin
               if (at_limit) begin
                  mode_in = MODE_IDLE;
                  cnt_in  = '0;
               end else begin
                  mode_in = MODE_COLLECT;
                  cnt_in  = cnt_ff + 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               if (in_byte == FLAG_BYTE) begin
                  mode_in = MODE_COLLECT;
                  cnt_in  = '0;
               end
            end
         endcase
      end
   end

   always_comb begin
      op_valid = 1'b0;
      op.kind  = OP_DATA;
      op.data  = dbyte;
      if (accept) begin
         unique case (mode_ff)
            MODE_COLLECT: begin
               if (in_byte == ESC_BYTE) begin
                  op_valid = 1'b0;
               end else if (in_byte == FLAG_BYTE) begin
                  op_valid = (cnt_ff != '0);
                  op.kind  = OP_CLOSE;
               end else begin
                  op_valid = 1'b1;
                  op.kind  = at_limit ? OP_ABORT : OP_DATA;
               end
            end
            MODE_ESCAPED: begin
               op_valid = 1'b1;
               op.kind  = at_limit ? OP_ABORT : OP_DATA;
            end
            default: begin
               op_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== sv/hadf_opq.sv =====
// ----------------------------------------------------------------------------
// HDLC deframer operation queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module hadf_opq
   import hadf_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   wr_valid,
   input  op_type wr_op,
   output logic   full,
   output logic   rd_valid,
   input  logic   rd_take,
   output op_type rd_op
);

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr;
   logic       do_rd;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_op    = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_take && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/hadf_back.sv =====
// ----------------------------------------------------------------------------
// HDLC deframer back end
// Holds back the last two bytes, runs the FCS-16, counts payload and
// drives the result register.
// ----------------------------------------------------------------------------
module hadf_back
   import hadf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       op_valid,
   input  op_type     op,
   output logic       op_take,
   output logic       out_valid,
   input  logic       out_pop,
   output logic [2:0] out_kind,
   output logic [7:0] out_byte,
   output logic [7:0] out_len
);

   logic [7:0]  hold0_ff, hold0_in;
   logic [7:0]  hold1_ff, hold1_in;
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  len_ff, len_in;
   logic        slot_free;
   logic        produce;

   assign slot_free = !valid_ff || out_pop;
   assign op_take   = op_valid && slot_free;

   always_comb begin
      hold0_in = hold0_ff;
      hold1_in = hold1_ff;
      hcnt_in  = hcnt_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      produce  = 1'b0;
      kind_in  = KIND_DATA;
      byte_in  = 8'h00;
      len_in   = 8'h00;
      if (op_take) begin
         case (op.kind)
            OP_DATA: begin
               if (hcnt_ff < 2'd2) begin
                  if (hcnt_ff == 2'd0) begin
                     hold0_in = op.data;
                  end else begin
                     hold1_in = op.data;
                  end
                  hcnt_in = hcnt_ff + 2'd1;
               end else begin
                  produce  = 1'b1;
                  byte_in  = hold0_ff;
                  crc_in   = fcs_update(crc_ff, hold0_ff);
                  count_in = count_ff + 8'd1;
                  hold0_in = hold1_ff;
                  hold1_in = op.data;
               end
            end
            OP_CLOSE: begin
               produce = 1'b1;
               len_in  = count_ff;
               if (hcnt_ff < 2'd2) begin
                  kind_in = KIND_SHORT;
               end else if (~crc_ff == {hold1_ff, hold0_ff}) begin
                  kind_in = KIND_GOOD;
               end else begin
                  kind_in = KIND_BADFCS;
               end
               hcnt_in  = 2'd0;
               crc_in   = FCS_INIT;
               count_in = 8'd0;
            end
            default: begin
               produce  = 1'b1;
               kind_in  = KIND_OVERFLOW;
               len_in   = count_ff;
               hcnt_in  = 2'd0;
               crc_in   = FCS_INIT;
               count_in = 8'd0;
            end
         endcase
      end
      valid_in = produce ? 1'b1 : (out_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      hold0_ff <= hold0_in;
      hold1_ff <= hold1_in;
      if (produce) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff  <= 2'd0;
         crc_ff   <= FCS_INIT;
         count_ff <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         hcnt_ff  <= hcnt_in;
         crc_ff   <= crc_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_len   = len_ff;

endmodule

// ===== tb/tb_hdlc_async_deframer_fcs16.sv =====
// ----------------------------------------------------------------------------
// Testbench for the asynchronous HDLC deframer with FCS-16 check
// Feeds raw line bytes through the push/full port: directed frames first, then
// random frames with random flaws and line noise. The expected data and status
// results come from a byte-level model of the deframer held in a scoreboard,
// and every result popped from the block is checked against it.
// ----------------------------------------------------------------------------
module tb_hdlc_async_deframer_fcs16;
   timeunit 1ns;
   timeprecision 1ps;

   import hadf_pkg::*;

   localparam int FRAME_LIMIT   = MAX_FRAME_DEFAULT;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BYTES   = 500;

   localparam int FLAW_NONE      = 0;
   localparam int FLAW_BAD_FCS   = 1;
   localparam int FLAW_NO_CLOSE  = 2;
   localparam int FLAW_ESC_CLOSE = 3;
   localparam int FLAW_ONE_BYTE  = 4;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] payload;
      logic [7:0] frame_len;
   } deframe_result_type;

   class deframe_scoreboard;
      front_mode_type     mode;
      logic [7:0]         held[2];
      int unsigned        held_n;
      logic [15:0]        crc;
      int unsigned        emitted;
      int unsigned        max_frame;
      int unsigned        mismatches;
      deframe_result_type expected_q[$];

      function new(int unsigned max_frame_len);
         max_frame  = max_frame_len;
         mismatches = 0;
         mode       = MODE_IDLE;
         clear_frame();
      endfunction

      static function logic [15:0] fcs16_next(logic [15:0] c, logic [7:0] b);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
               c = c ^ FCS_POLY;
            end
         end
         return c;
      endfunction

      function void clear_frame();
         held[0] = 8'h00;
         held[1] = 8'h00;
         held_n  = 0;
         crc     = FCS_INIT;
         emitted = 0;
      endfunction

      function void add_expected(logic [2:0] kind, logic [7:0] data, int unsigned len);
         deframe_result_type r;
         r.kind      = kind;
         r.payload   = data;
         r.frame_len = len[7:0];
         expected_q.push_back(r);
      endfunction

      function void take_byte(logic [7:0] b);
         if (held_n < 2) begin
            held[held_n] = b;
            held_n++;
         end else if (emitted >= max_frame) begin
            add_expected(KIND_OVERFLOW, 8'h00, emitted);
            clear_frame();
            mode = MODE_IDLE;
         end else begin
            add_expected(KIND_DATA, held[0], 0);
            crc     = fcs16_next(crc, held[0]);
            emitted++;
            held[0] = held[1];
            held[1] = b;
         end
      endfunction

      function void note_input(logic [7:0] b);
         logic [2:0] kind;
         case (mode)
            MODE_ESCAPED: begin
               mode = MODE_COLLECT;
               take_byte(b ^ ESC_XOR);
            end
            MODE_COLLECT: begin
               if (b == ESC_BYTE) begin
                  mode = MODE_ESCAPED;
               end else if (b == FLAG_BYTE) begin
                  if (held_n != 0) begin
                     if (held_n < 2) begin
                        kind = KIND_SHORT;
                     end else if ({held[1], held[0]} == ~crc) begin
                        kind = KIND_GOOD;
                     end else begin
                        kind = KIND_BADFCS;
                     end
                     add_expected(kind, 8'h00, emitted);
                     clear_frame();
                     mode = MODE_IDLE;
                  end
               end else begin
                  take_byte(b);
               end
            end
            default: begin
               mode = MODE_IDLE;
               if (b == FLAG_BYTE) begin
                  clear_frame();
                  mode = MODE_COLLECT;
               end
            end
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 100) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
      endtask

      task check_result(logic [2:0] kind, logic [7:0] data, logic [7:0] len);
         deframe_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h length %0d",
                                      kind, data, len));
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind) begin
            report_mismatch($sformatf("result_kind %0d, expected %0d", kind, want.kind));
         end
         if (data !== want.payload) begin
            report_mismatch($sformatf("payload_byte %02h, expected %02h", data, want.payload));
         end
         if (len !== want.frame_len) begin
            report_mismatch($sformatf("frame_length %0d, expected %0d", len, want.frame_len));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_frame_length;

   deframe_scoreboard sb;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_request  = 1'b0;

   hdlc_async_deframer_fcs16 #(
      .MAX_FRAME(FRAME_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_rx_byte     (req_rx_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_frame_length(rsp_frame_length)
   );

   always #10 clock = ~clock;

   // Leaves push high after the transfer, so that back-to-back bytes keep it
   // asserted; drain lowers it, as do idle gaps before a byte.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(posedge clock);
      end while (req_full);
      sb.note_input(b);
   endtask

   task automatic send_line(input logic [7:0] line[$]);
      foreach (line[i]) begin
         send_byte(line[i]);
      end
   endtask

   task automatic send_frame(input logic [7:0] body[$], input int flaw,
                             output int unsigned n_sent);
      logic [7:0]  wire_q[$];
      logic [15:0] fcs;
      int          k;
      fcs = FCS_INIT;
      foreach (body[i]) begin
         fcs = deframe_scoreboard::fcs16_next(fcs, body[i]);
      end
      fcs = ~fcs;
      body.push_back(fcs[7:0]);
      body.push_back(fcs[15:8]);
      if (flaw == FLAW_BAD_FCS) begin
         k       = body.size() - 1 - $urandom_range(1);
         body[k] = body[k] ^ (8'h01 << $urandom_range(7));
      end
      if (flaw == FLAW_ONE_BYTE) begin
         while (body.size() > 1) begin
            void'(body.pop_back());
         end
      end
      wire_q.push_back(FLAG_BYTE);
      if ($urandom_range(3) == 0) begin
         wire_q.push_back(FLAG_BYTE);
      end
      foreach (body[i]) begin
         if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE || $urandom_range(15) == 0) begin
            wire_q.push_back(ESC_BYTE);
            wire_q.push_back(body[i] ^ ESC_XOR);
         end else begin
            wire_q.push_back(body[i]);
         end
      end
      if (flaw == FLAW_ESC_CLOSE) begin
         wire_q.push_back(ESC_BYTE);
         wire_q.push_back(FLAG_BYTE);
      end
      if (flaw != FLAW_NO_CLOSE) begin
         wire_q.push_back(FLAG_BYTE);
      end
      send_line(wire_q);
      n_sent = wire_q.size();
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic random_traffic(input int unsigned first_len, input int unsigned quota);
      logic [7:0]  body[$];
      int unsigned sent;
      int unsigned n;
      int unsigned len;
      int          flaw;
      int          r;
      sent = 0;
      len  = first_len;
      flaw = FLAW_NONE;
      while (sent < quota) begin
         body.delete();
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
               0:       body.push_back(FLAG_BYTE);
               1:       body.push_back(ESC_BYTE);
               default: body.push_back(8'($urandom_range(255)));
            endcase
         end
         send_frame(body, flaw, n);
         sent += n;
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
         end
         r = $urandom_range(99);
         if (r < 3) begin
            len = $urandom_range(FRAME_LIMIT - 2, FRAME_LIMIT + 3);
         end else if (r < 10) begin
            len = $urandom_range(13, 60);
         end else begin
            len = $urandom_range(0, 12);
         end
         r = $urandom_range(99);
         if (r < 75) begin
            flaw = FLAW_NONE;
         end else if (r < 85) begin
            flaw = FLAW_BAD_FCS;
         end else if (r < 90) begin
            flaw = FLAW_NO_CLOSE;
         end else if (r < 95) begin
            flaw = FLAW_ESC_CLOSE;
         end else begin
            flaw = FLAW_ONE_BYTE;
         end
      end
   endtask

   initial begin
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            sb.check_result(rsp_result_kind, rsp_payload_byte, rsp_frame_length);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop     <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int unsigned n;
      sb = new(FRAME_LIMIT);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle bytes, fill flags, a short frame and a frame holding only its FCS.
      send_line('{8'h00, 8'hFF, ESC_BYTE,
                  FLAG_BYTE, FLAG_BYTE, 8'hA5, FLAG_BYTE,
                  FLAG_BYTE, 8'h00, 8'h00, FLAG_BYTE});
      send_frame('{FLAG_BYTE, ESC_BYTE, 8'hFF}, FLAW_NONE, n);
      send_frame('{8'h00}, FLAW_BAD_FCS, n);
      // An escaped flag is taken as data and does not close the frame.
      send_line('{FLAG_BYTE, 8'h11, ESC_BYTE, FLAG_BYTE, FLAG_BYTE});
      drain();

      send_idle_pct = 20;
      recv_idle_pct = 48;
      hold_request  = 1'b1;
      random_traffic(FRAME_LIMIT + 1, PHASE_BYTES);
      drain();

      send_idle_pct = 48;
      recv_idle_pct = 20;
      random_traffic(FRAME_LIMIT, PHASE_BYTES);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      random_traffic(5, PHASE_BYTES);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
